// ===== rtl/cref_pkg.sv =====
// Shared types, constants and helpers for the clipped rectangle fill engine.
`timescale 1ns / 1ps

package cref_pkg;

    localparam int ADDR_W     = 48;
    localparam int DIM_W      = 14;
    localparam int COORD_W    = 16;
    localparam int COLOR_W    = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 48;
    localparam int IN_DATA_W  = 4 * COORD_W + COLOR_W;   // 96, already whole bytes
    localparam int OUT_DATA_W = ADDR_W + COLOR_W;         // 80, already whole bytes

    localparam logic [DIM_W-1:0] MAX_DIM = 14'd8192;

    localparam logic [CFG_IDX_W-1:0] CFG_FB_BASE       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_PIXELS = 8'd3;

    typedef enum logic [1:0] {
        OP_FILL  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [COORD_W-1:0] rect_x;
        logic [COORD_W-1:0] rect_y;
        logic [COORD_W-1:0] rect_width;
        logic [COORD_W-1:0] rect_height;
        logic [COLOR_W-1:0] fill_color;
    } t_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0]  write_addr;
        logic [COLOR_W-1:0] write_color;
        logic               last_write;
    } t_wr;

    function automatic logic [DIM_W-1:0] dim_sat(input logic [DIM_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

endpackage

// ===== rtl/cref_core.sv =====
// Command decode, clipping, job state and pixel address stepping.
`timescale 1ns / 1ps

module cref_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cref_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cref_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_exec,
    input  cref_pkg::t_cmd                i_cmd,
    output logic                          o_wr_valid,
    output cref_pkg::t_wr                 o_wr
);
    import cref_pkg::*;

    // configuration
    logic [ADDR_W-1:0] r_fb_base;
    logic [DIM_W-1:0]  r_screen_width;
    logic [DIM_W-1:0]  r_screen_height;
    logic [DIM_W-1:0]  r_stride_pixels;

    // job state
    logic              r_busy,      n_busy;
    logic [ADDR_W-1:0] r_row_start, n_row_start;
    logic [DIM_W-1:0]  r_col_count, n_col_count;
    logic [DIM_W-1:0]  r_span_len,  n_span_len;
    logic [DIM_W-1:0]  r_rows_left, n_rows_left;
    logic [COLOR_W-1:0] r_held_color, n_held_color;

    // fill setup
    logic [COORD_W:0]   x_end, y_end;
    logic               off_screen;
    logic [DIM_W-1:0]   fill_cols, fill_rows;
    logic [2*DIM_W-1:0] line_off;
    logic [ADDR_W-1:0]  fill_addr;

    // tick
    logic               row_end, last;
    logic [ADDR_W-1:0]  pix_addr;

    always_comb begin
        x_end      = {1'b0, i_cmd.rect_x} + {1'b0, i_cmd.rect_width};
        y_end      = {1'b0, i_cmd.rect_y} + {1'b0, i_cmd.rect_height};
        off_screen = (i_cmd.rect_x >= {2'b0, r_screen_width}) ||
                     (i_cmd.rect_y >= {2'b0, r_screen_height});
        fill_cols  = (x_end > {3'b0, r_screen_width}) ?
                     r_screen_width - i_cmd.rect_x[DIM_W-1:0] : i_cmd.rect_width[DIM_W-1:0];
        fill_rows  = (y_end > {3'b0, r_screen_height}) ?
                     r_screen_height - i_cmd.rect_y[DIM_W-1:0] : i_cmd.rect_height[DIM_W-1:0];
        // y < screen_height <= 8192, so 13 bits of y carry the row
        line_off   = {1'b0, i_cmd.rect_y[DIM_W-2:0]} * r_stride_pixels
                     + {{DIM_W{1'b0}}, i_cmd.rect_x[DIM_W-1:0]};
        fill_addr  = r_fb_base + {{(ADDR_W-2*DIM_W-2){1'b0}}, line_off, 2'b00};

        row_end  = ({1'b0, r_col_count} + 15'd1) >= {1'b0, r_span_len};
        last     = row_end && (r_rows_left <= 14'd1);
        pix_addr = r_row_start + {{(ADDR_W-DIM_W-2){1'b0}}, r_col_count, 2'b00};
    end

    always_comb begin
        n_busy       = r_busy;
        n_row_start  = r_row_start;
        n_col_count  = r_col_count;
        n_span_len   = r_span_len;
        n_rows_left  = r_rows_left;
        n_held_color = r_held_color;
        o_wr_valid   = 1'b0;
        o_wr.write_addr  = pix_addr;
        o_wr.write_color = r_held_color;
        o_wr.last_write  = last;
        if (i_exec) begin
            case (i_cmd.op)
                OP_FILL: begin
                    if (!r_busy && (r_fb_base != '0) && !off_screen &&
                        (fill_cols != '0) && (fill_rows != '0)) begin
                        n_busy       = 1'b1;
                        n_row_start  = fill_addr;
                        n_col_count  = '0;
                        n_span_len   = fill_cols;
                        n_rows_left  = fill_rows;
                        n_held_color = i_cmd.fill_color;
                    end
                end
                OP_CLEAR: begin
                    if (!r_busy && (r_fb_base != '0) &&
                        (r_stride_pixels != '0) && (r_screen_height != '0)) begin
                        n_busy       = 1'b1;
                        n_row_start  = r_fb_base;
                        n_col_count  = '0;
                        n_span_len   = r_stride_pixels;
                        n_rows_left  = r_screen_height;
                        n_held_color = i_cmd.fill_color;
                    end
                end
                OP_TICK: begin
                    if (r_busy) begin
                        o_wr_valid = 1'b1;
                        if (row_end) begin
                            n_col_count = '0;
                            n_rows_left = (r_rows_left != '0) ? r_rows_left - 14'd1 : '0;
                            // live stride sets the row step
                            n_row_start = r_row_start +
                                {{(ADDR_W-DIM_W-2){1'b0}}, r_stride_pixels, 2'b00};
                            if (r_rows_left <= 14'd1) begin
                                n_busy = 1'b0;
                            end
                        end else begin
                            n_col_count = r_col_count + 14'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_base       <= '0;
            r_screen_width  <= '0;
            r_screen_height <= '0;
            r_stride_pixels <= '0;
            r_busy          <= 1'b0;
            r_row_start     <= '0;
            r_col_count     <= '0;
            r_span_len      <= '0;
            r_rows_left     <= '0;
            r_held_color    <= '0;
        end else begin
            r_busy       <= n_busy;
            r_row_start  <= n_row_start;
            r_col_count  <= n_col_count;
            r_span_len   <= n_span_len;
            r_rows_left  <= n_rows_left;
            r_held_color <= n_held_color;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FB_BASE:       r_fb_base       <= i_cfg_data[ADDR_W-1:0];
                    CFG_SCREEN_WIDTH:  r_screen_width  <= dim_sat(i_cfg_data[DIM_W-1:0]);
                    CFG_SCREEN_HEIGHT: r_screen_height <= dim_sat(i_cfg_data[DIM_W-1:0]);
                    CFG_STRIDE_PIXELS: r_stride_pixels <= dim_sat(i_cfg_data[DIM_W-1:0]);
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/clipped_rect_fill_engine_unit.sv =====
// Top level of the clipped rectangle fill engine: stream ports, input stage, output skid.
`timescale 1ns / 1ps

// Usage:
//   Slave stream carries commands. tuser holds op: fill, clear or tick. tdata holds
//   the rectangle and color. Fill and clear start a job and return nothing; each tick
//   while a job runs returns one pixel write on the master stream (address, color,
//   tlast on the final pixel of the job). Ticks while idle and ignored commands return
//   nothing.
//   Configuration: write fb_base, screen_width, screen_height and stride_pixels through
//   the plain write port while the engine is idle.
//   Pipeline: a tick beat is registered on input, executes combinationally from the input
//   register and its pixel write is registered in the output register, from which the
//   master side accepts it. Throughput: one beat per cycle while the skid register is
//   empty, set by the execute stage (clip multiply plus 48-bit address add).
//   Stall: a full output register spills into a one-entry skid register; the input
//   stage stops taking beats only when the skid register is occupied.
//   Reset (synchronous, active low) clears configuration, job state and all valids.

module clipped_rect_fill_engine_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cref_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cref_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // rect_x, rect_y, rect_width, rect_height, fill_color
    input  logic [cref_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // op
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // write_addr, write_color
    output logic [cref_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast
);
    import cref_pkg::*;

    logic  r_in_valid;
    t_cmd  r_in_cmd;
    logic  r_out_valid;
    t_wr   r_out;
    logic  r_skid_valid;
    t_wr   r_skid;

    logic  exec;
    logic  wr_valid;
    t_wr   wr;

    // skid empty means the result of an executing beat always has a place
    assign exec          = r_in_valid && !r_skid_valid;
    assign s_axis_tready = !r_in_valid || exec;

    cref_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_exec     (exec),
        .i_cmd      (r_in_cmd),
        .o_wr_valid (wr_valid),
        .o_wr       (wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (r_out_valid && !m_axis_tready) begin
                if (exec && wr_valid) begin
                    r_skid_valid <= 1'b1;
                end
            end else if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= exec && wr_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd.op          <= t_op'(s_axis_tuser);
            r_in_cmd.rect_x      <= s_axis_tdata[15:0];
            r_in_cmd.rect_y      <= s_axis_tdata[31:16];
            r_in_cmd.rect_width  <= s_axis_tdata[47:32];
            r_in_cmd.rect_height <= s_axis_tdata[63:48];
            r_in_cmd.fill_color  <= s_axis_tdata[95:64];
        end
        if (r_out_valid && !m_axis_tready) begin
            if (exec && wr_valid) begin
                r_skid <= wr;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else begin
            r_out <= wr;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.write_color, r_out.write_addr};
    assign m_axis_tlast  = r_out.last_write;

endmodule
